/* sv/wvp_pkg.sv */
// ----------------------------------------------------------------------------
// wvp_pkg
// Shared types and constants of the world-to-viewport projector.
// ----------------------------------------------------------------------------
package wvp_pkg;

    localparam int COEF_W  = 32;
    localparam int PROD_W  = 2 * COEF_W;
    localparam int CLIP_W  = 50;           // three floored products plus bias
    localparam int DIV_W   = CLIP_W + 1;   // c + w and 2w
    localparam int FRAC_W  = 16;
    localparam int T_W     = FRAC_W + 1;   // 0 .. 65536
    localparam int SIZE_W  = 13;
    localparam int PIX_W   = 29;
    localparam int DEPTH_W = 17;
    localparam logic [PIX_W-1:0] PIXEL_MAX = PIX_W'(268435456);

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [3:0]        coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [DEPTH_W-1:0] depth;
        logic               visible;
    } out_item_t;

    typedef struct packed {
        logic                     we;
        logic [3:0]               index;
        logic signed [COEF_W-1:0] value;
    } coef_load_t;

endpackage

/* sv/wvp_transform.sv */
// ----------------------------------------------------------------------------
// wvp_transform
// Coefficient store and two-stage 4x4 matrix times point (w = 1).
// ----------------------------------------------------------------------------
module wvp_transform
    import wvp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  coef_load_t               load,
    input  logic signed [COEF_W-1:0] px,
    input  logic signed [COEF_W-1:0] py,
    input  logic signed [COEF_W-1:0] pz,
    output logic signed [CLIP_W-1:0] clip [4]
);

    logic signed [COEF_W-1:0] mat_reg [16];
    logic signed [PROD_W-1:0] prod_reg [4][3];
    logic signed [COEF_W-1:0] bias_reg [4];
    logic signed [CLIP_W-1:0] clip_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (load.we)
        begin
            mat_reg[load.index] <= load.value;
        end
    end

    // stage 1: twelve products, bias column captured with them
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r][0] <= mat_reg[r*4+0] * px;
                prod_reg[r][1] <= mat_reg[r*4+1] * py;
                prod_reg[r][2] <= mat_reg[r*4+2] * pz;
                bias_reg[r]    <= mat_reg[r*4+3];
            end
        end
    end

    // stage 2: floor each product to q16 and sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                clip_reg[r] <= CLIP_W'($signed(prod_reg[r][0][PROD_W-1:16]))
                             + CLIP_W'($signed(prod_reg[r][1][PROD_W-1:16]))
                             + CLIP_W'($signed(prod_reg[r][2][PROD_W-1:16]))
                             + CLIP_W'(bias_reg[r]);
            end
        end
    end

    assign clip = clip_reg;

endmodule

/* sv/wvp_frac_div.sv */
// ----------------------------------------------------------------------------
// wvp_frac_div
// Pipelined restoring divider: floor(65536 * num / den), num <= den.
// ----------------------------------------------------------------------------
module wvp_frac_div
    import wvp_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic [T_W-1:0]   quo
);

    logic [DIV_W-1:0] rem_reg [FRAC_W+1];
    logic [DIV_W-1:0] den_reg [FRAC_W+1];
    logic [T_W-1:0]   q_reg   [FRAC_W+1];

    // integer part is one only when num equals den
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= (num == den) ? '0 : num;
            den_reg[0] <= den;
            q_reg[0]   <= T_W'(num == den);
        end
    end

    for (genvar s = 1; s <= FRAC_W; s++)
    begin : g_step
        logic [DIV_W:0] dbl;
        logic           ge;
        assign dbl = {rem_reg[s-1], 1'b0};
        assign ge  = dbl >= {1'b0, den_reg[s-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? DIV_W'(dbl - {1'b0, den_reg[s-1]}) : DIV_W'(dbl);
                den_reg[s] <= den_reg[s-1];
                q_reg[s]   <= {q_reg[s-1][T_W-2:0], ge};
            end
        end
    end

    assign quo = q_reg[FRAC_W];

endmodule

/* sv/world_to_viewport_projector.sv */
// ----------------------------------------------------------------------------
// world_to_viewport_projector
// Matrix transform, clip test, perspective divide and viewport scaling.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; the whole pipeline stalls while the output
// register holds a result that is not taken
// load items write a coefficient at transfer and give no result
// reset clears the matrix and valid bits, viewport goes to 640 x 480
module world_to_viewport_projector
    import wvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam int DLAT = FRAC_W + 1;

    logic              adv;
    logic              in_xfer;
    coef_load_t        load;
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [2:0]        v_reg;
    logic [DLAT-1:0]   dv_reg, dvis_reg;
    logic              vis_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic [DIV_W-1:0]  num_reg [3];
    logic [DIV_W-1:0]  den_reg;
    logic signed [CLIP_W-1:0] clip [4];
    logic [T_W-1:0]    t [3];
    logic signed [DIV_W-1:0] cw, cneg;
    logic              vis_next;
    logic [SIZE_W+T_W-1:0] sx, sy;

    assign adv     = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign in_xfer = in_valid && adv;

    assign load.we    = in_xfer && (in_item.opcode == OP_LOAD);
    assign load.index = in_item.coef_index;
    assign load.value = in_item.coef_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(640);
            height_reg <= SIZE_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    wvp_transform u_xform (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .load  (load),
        .px    (in_item.point_x),
        .py    (in_item.point_y),
        .pz    (in_item.point_z),
        .clip  (clip)
    );

    // stage 3: clip test and divider operands
    assign cw   = DIV_W'(clip[3]);
    assign cneg = -cw;
    always_comb
    begin
        vis_next = clip[3] > 0;
        for (int k = 0; k < 3; k++)
        begin
            if (DIV_W'(clip[k]) > cw || DIV_W'(clip[k]) < cneg)
            begin
                vis_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= vis_next ? DIV_W'(DIV_W'(clip[k]) + cw) : '0;
            end
            den_reg <= vis_next ? {clip[3], 1'b0} : DIV_W'(1);
            vis_reg <= vis_next;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        wvp_frac_div u_div (
            .clk (clk),
            .en  (adv),
            .num (num_reg[k]),
            .den (den_reg),
            .quo (t[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvis_reg <= {dvis_reg[DLAT-2:0], vis_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[1:0], in_xfer && (in_item.opcode == OP_PROJECT)};
            dv_reg        <= {dv_reg[DLAT-2:0], v_reg[2]};
            out_valid_reg <= dv_reg[DLAT-1];
        end
    end

    // final stage: scale to viewport and saturate
    assign sx = T_W'(t[0]) * width_reg;
    assign sy = T_W'(t[1]) * height_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dvis_reg[DLAT-1])
            begin
                out_item_reg.pixel_x <= (sx > (SIZE_W+T_W)'(PIXEL_MAX)) ? PIXEL_MAX
                                                                      : PIX_W'(sx);
                out_item_reg.pixel_y <= (sy > (SIZE_W+T_W)'(PIXEL_MAX)) ? PIXEL_MAX
                                                                      : PIX_W'(sy);
                out_item_reg.depth   <= DEPTH_W'(t[2]);
                out_item_reg.visible <= 1'b1;
            end
            else
            begin
                out_item_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.visible |->
            out_item.pixel_x == '0 && out_item.pixel_y == '0 && out_item.depth == '0)
        else $error("hidden point with nonzero fields");

    a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.pixel_x <= PIXEL_MAX && out_item.pixel_y <= PIXEL_MAX)
        else $error("pixel out of range");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.depth <= DEPTH_W'(65536))
        else $error("depth out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline stalled");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Directed and randomized check of the world-to-viewport projector. A scoreboard mirrors
// the coefficient matrix and viewport size, predicts every projected point
// and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import wvp_pkg::*;

    class proj_scoreboard;
        logic signed [31:0] mat [16];
        int unsigned        vp_w;
        int unsigned        vp_h;
        out_item_t          pending [$];
        int                 errs;

        function void clear();
            foreach (mat[i]) mat[i] = '0;
            vp_w = 640;
            vp_h = 480;
            pending.delete();
            errs = 0;
        endfunction

        function void set_size(logic idx, int unsigned val);
            if (idx == REG_WIDTH) vp_w = val;
            else vp_h = val;
        endfunction

        function logic [PIX_W-1:0] scale(bit [79:0] t, int unsigned sz);
            longint v;
            v = longint'(t) * longint'(sz);
            return (v > 268435456) ? PIXEL_MAX : PIX_W'(v);
        endfunction

        // notes an accepted input: loads update the matrix, points are predicted
        function void note_input(in_item_t it);
            longint    pt [3];
            longint    cl [4];
            longint    acc;
            longint    mag;
            bit [79:0] t [3];
            bit [79:0] den;
            out_item_t e;
            bit        vis;
            if (it.opcode == OP_LOAD)
            begin
                mat[it.coef_index] = it.coef_value;
                return;
            end
            pt[0] = longint'(it.point_x);
            pt[1] = longint'(it.point_y);
            pt[2] = longint'(it.point_z);
            for (int r = 0; r < 4; r++)
            begin
                acc = longint'(mat[r*4+3]);
                for (int k = 0; k < 3; k++)
                    acc += (longint'(mat[r*4+k]) * pt[k]) >>> 16;
                cl[r] = acc;
            end
            e = '0;
            vis = (cl[3] > 0);
            for (int k = 0; k < 3; k++)
            begin
                mag = (cl[k] < 0) ? -cl[k] : cl[k];
                if (mag > cl[3]) vis = 0;
            end
            if (vis)
            begin
                den = 80'(2 * cl[3]);
                for (int k = 0; k < 3; k++)
                    t[k] = (80'(cl[k] + cl[3]) << 16) / den;
                e.pixel_x = scale(t[0], vp_w);
                e.pixel_y = scale(t[1], vp_h);
                e.depth   = DEPTH_W'(t[2]);
                e.visible = 1'b1;
            end
            pending.push_back(e);
        endfunction

        function void check(out_item_t got);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %p", got);
                errs++;
                return;
            end
            e = pending.pop_front();
            if (got.pixel_x !== e.pixel_x)
            begin
                $error("pixel_x exp %0d got %0d", e.pixel_x, got.pixel_x);
                errs++;
            end
            if (got.pixel_y !== e.pixel_y)
            begin
                $error("pixel_y exp %0d got %0d", e.pixel_y, got.pixel_y);
                errs++;
            end
            if (got.depth !== e.depth)
            begin
                $error("depth exp %0d got %0d", e.depth, got.depth);
                errs++;
            end
            if (got.visible !== e.visible)
            begin
                $error("visible exp %0d got %0d", e.visible, got.visible);
                errs++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_item;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_item;
    logic              cfg_we;
    logic              cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    proj_scoreboard sb;
    int             cycles = 0;
    bit             hold_req;
    int             hold_left;
    int             stall_mode;

    world_to_viewport_projector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    initial
    begin
        sb = new();
        sb.clear();
    end

    // transfer monitors
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready) sb.note_input(in_item);
        if (rst_n && out_valid && out_ready) sb.check(out_item);
    end

    // receiver: own stall pattern, plus a long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_left  <= 0;
            stall_mode <= 0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            out_ready <= 1'b0;
            hold_left <= 300;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_size(logic idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= SIZE_W'(val);
        sb.set_size(idx, val);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // leaves valid high; gaps lower it
    task automatic send(in_item_t it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic idle(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic in_item_t noise_item();
        in_item_t it;
        it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom});
        return it;
    endfunction

    function automatic in_item_t load_item(int idx, logic signed [31:0] v);
        in_item_t it;
        it = noise_item();
        it.opcode     = OP_LOAD;
        it.coef_index = 4'(idx);
        it.coef_value = v;
        return it;
    endfunction

    function automatic in_item_t point_item(int x, int y, int z);
        in_item_t it;
        it = noise_item();
        it.opcode  = OP_PROJECT;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        return it;
    endfunction

    function automatic int small_q(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic load_identity();
        for (int i = 0; i < 16; i++)
            send(load_item(i, (i % 5 == 0) ? 32'sh10000 : 32'sh0));
    endtask

    // projection-like matrix with random content, positive w bias
    task automatic load_projection();
        int v;
        for (int i = 0; i < 16; i++)
        begin
            if (i == 15) v = int'($urandom_range(32768, 196608));
            else if (i == 14) v = small_q(32768);
            else if (i > 11) v = small_q(4096);
            else if (i % 5 == 0) v = small_q(131072);
            else v = small_q(16384);
            send(load_item(i, v));
        end
    endtask

    task automatic burst_points(int n);
        int left;
        in_item_t it;
        left = n;
        while (left > 0)
        begin
            for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--)
            begin
                case ($urandom_range(0, 9))
                    0:       it = noise_item();
                    1:       it = load_item($urandom_range(0, 15), small_q(131072));
                    default: it = point_item(small_q(131072), small_q(131072),
                                             small_q(131072));
                endcase
                send(it);
                left--;
            end
            if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        int unsigned sizes [6][2];
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = '0;
        hold_req  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero matrix gives w = 0, then identity corners, negative w and extreme values
        send(point_item(32'sh10000, 0, 0));
        load_identity();
        send(point_item(0, 0, 0));
        send(point_item(32'sh10000, 32'sh10000, 32'sh10000));
        send(point_item(-32'sh10000, -32'sh10000, -32'sh10000));
        send(point_item(32'sh10001, 0, 0));
        send(point_item(32'h7fffffff, 32'h80000000, 0));
        send(point_item(32'h80000000, 32'h7fffffff, 32'h7fffffff));
        send(load_item(15, -32'sh10000));
        send(point_item(0, 0, 0));
        send(load_item(15, 32'h7fffffff));
        send(load_item(0, 32'h80000000));
        send(point_item(32'sh8000, -32'sh8000, 32'sh4000));
        send(load_item(5, 32'h7fffffff));
        send(point_item(32'h7fffffff, 32'h7fffffff, 32'h80000000));
        drain();

        sizes = '{'{640, 480}, '{1, 1}, '{4096, 4096}, '{8191, 8191},
                  '{0, 0}, '{0, 0}};
        sizes[5][0] = $urandom_range(1, 4096);
        sizes[5][1] = $urandom_range(1, 4096);
        for (int ph = 0; ph < 12; ph++)
        begin
            write_size(REG_WIDTH, sizes[ph % 6][0]);
            write_size(REG_HEIGHT, sizes[ph % 6][1]);
            load_projection();
            if (ph == 3)
            begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            burst_points(58);
            drain();
        end

        drain();
        if (sb.errs == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
sv/wvp_pkg.sv
sv/wvp_transform.sv
sv/wvp_frac_div.sv
sv/world_to_viewport_projector.sv
tb/sv/tb.sv
